// ===== hw/rtl/scr_pkg.sv =====
// Shared types, constants and helpers for the colex subset rank/unrank block.
package scr_pkg;

    localparam int C_MAX_POINTS = 64;
    localparam int C_TBL_ROWS   = C_MAX_POINTS + 1;
    localparam int C_TBL_DEPTH  = C_TBL_ROWS * C_TBL_ROWS;
    localparam int C_ADDR_W     = $clog2(C_TBL_DEPTH);
    localparam int C_POS_W      = $clog2(C_MAX_POINTS);
    localparam int C_CNT_W      = $clog2(C_MAX_POINTS + 1);

    localparam logic [1:0] ACT_RANK       = 2'd0;
    localparam logic [1:0] ACT_UNRANK     = 2'd1;
    localparam logic [1:0] ACT_RST_RANK   = 2'd2;
    localparam logic [1:0] ACT_RST_UNRANK = 2'd3;

    // Binomial table read request: C(row, col).
    typedef struct packed {
        logic [C_CNT_W-1:0] row;
        logic [C_CNT_W-1:0] col;
    } t_tbl_req;

    typedef enum logic [3:0] {
        S_FILL,
        S_IDLE,
        S_RANK,
        S_RANK_LAST,
        S_U_COUNT,
        S_U_CHK,
        S_U_CHKW,
        S_U_ALIGN,
        S_U_TEST
    } t_state;

    // Row-major address of C(row, col), rows of C_TBL_ROWS entries.
    function automatic logic [C_ADDR_W-1:0] tbl_addr(input logic [C_CNT_W-1:0] row,
                                                     input logic [C_CNT_W-1:0] col);
        logic [C_ADDR_W-1:0] prod;
        prod = C_ADDR_W'(row) * C_ADDR_W'(C_TBL_ROWS);
        return prod + C_ADDR_W'(col);
    endfunction

endpackage

// ===== hw/rtl/subset_colex_rank_unrank.sv =====
// Top level: colex subset rank / unrank sequencer around a shared binomial table.
//
//  channel   | direction | handshake                  | payload
//  ----------+-----------+----------------------------+------------------------------------
//  command   | in        | start, busy                | i_action, i_subset_mask,
//            |           |                            | i_blocked_mask, i_rank_value,
//            |           |                            | i_element_count
//  result    | out       | o_strobe (one cycle)       | o_answer, o_out_of_range
//  config    | in        | i_cfg_valid, o_cfg_ready   | i_cfg_data (point_count)
//
// An item is taken when start is high and busy is low; busy rises the next cycle.
// Rank: one point position per cycle, then S_RANK_LAST folds in the last table read.
// Unrank: count free points over the n positions, run the feasibility check
// (S_U_CHK, S_U_CHKW), then S_U_ALIGN and S_U_TEST for each table index tested
// (at most m), plus one more S_U_ALIGN step per blocked position skipped. The
// single table read port paces every step. After reset the table is built, each
// entry read then written, before leaving the fill state; busy stays high.
// The result strobe is one cycle wide; the receiver cannot stall it. Config is
// always ready and is meant to be written while busy is low.
module subset_colex_rank_unrank (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_action,
    input  logic [63:0] i_subset_mask,
    input  logic [63:0] i_blocked_mask,
    input  logic [63:0] i_rank_value,
    input  logic [6:0]  i_element_count,
    output logic        o_strobe,
    output logic [63:0] o_answer,
    output logic        o_out_of_range,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [6:0]  i_cfg_data
);
    import scr_pkg::*;

    t_state             r_state, n_state;
    logic [C_POS_W-1:0] r_cnt,   n_cnt;    // scan position
    logic [C_POS_W-1:0] r_idx,   n_idx;    // index among numbered points
    logic [C_POS_W-1:0] r_pos,   n_pos;    // board position of r_idx (unrank)
    logic [C_CNT_W-1:0] r_ord,   n_ord;    // rank: order so far; unrank: order i
    logic [C_CNT_W-1:0] r_m,     n_m;      // free point count
    logic [C_CNT_W-1:0] r_k,     n_k;
    logic               r_pend,  n_pend;   // table read outstanding (rank)
    logic               r_restr, n_restr;
    logic [63:0]        r_acc,   n_acc;
    logic [63:0]        r_rank,  n_rank;
    logic [63:0]        r_sub,   n_sub;
    logic [63:0]        r_blk,   n_blk;
    logic               r_strobe, n_strobe;
    logic [63:0]        r_answer, n_answer;
    logic               r_flag,   n_flag;
    logic [6:0]         r_point_count;

    t_tbl_req           tbl_req;
    logic [63:0]        tbl_data;
    logic               tbl_ready;

    logic [C_CNT_W-1:0] pts_eff;
    logic [C_POS_W-1:0] pos_last;
    logic [64:0]        diff;      // shared compare / subtract
    logic [63:0]        acc_sum;
    logic               cur_free;
    logic               pos_blocked;
    logic               act_unrank;
    logic               act_restr;

    scr_binom u_binom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (tbl_req),
        .o_data  (tbl_data),
        .o_ready (tbl_ready)
    );

    // point_count above the board size saturates
    assign pts_eff  = (r_point_count > C_CNT_W'(C_MAX_POINTS)) ? C_CNT_W'(C_MAX_POINTS)
                                                               : r_point_count;
    assign pos_last = C_POS_W'(pts_eff - C_CNT_W'(1));

    assign diff        = {1'b0, r_rank} - {1'b0, tbl_data};
    assign acc_sum     = r_acc + tbl_data;
    assign cur_free    = ~(r_restr & r_blk[r_cnt]);
    assign pos_blocked = r_restr & r_blk[r_pos];

    always_comb begin
        act_unrank = 1'b0;
        act_restr  = 1'b0;
        unique case (i_action)
            ACT_RANK:       begin act_unrank = 1'b0; act_restr = 1'b0; end
            ACT_UNRANK:     begin act_unrank = 1'b1; act_restr = 1'b0; end
            ACT_RST_RANK:   begin act_unrank = 1'b0; act_restr = 1'b1; end
            ACT_RST_UNRANK: begin act_unrank = 1'b1; act_restr = 1'b1; end
            default:        begin act_unrank = 1'b0; act_restr = 1'b0; end
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_idx    = r_idx;
        n_pos    = r_pos;
        n_ord    = r_ord;
        n_m      = r_m;
        n_k      = r_k;
        n_pend   = r_pend;
        n_restr  = r_restr;
        n_acc    = r_acc;
        n_rank   = r_rank;
        n_sub    = r_sub;
        n_blk    = r_blk;
        n_strobe = 1'b0;
        n_answer = r_answer;
        n_flag   = r_flag;
        tbl_req.row = C_CNT_W'(r_idx);
        tbl_req.col = r_ord;

        unique case (r_state)
            S_FILL: begin
                if (tbl_ready) begin
                    n_state = S_IDLE;
                end
            end

            S_IDLE: begin
                if (start) begin
                    n_restr = act_restr;
                    n_sub   = i_subset_mask;
                    n_blk   = i_blocked_mask;
                    n_rank  = i_rank_value;
                    n_k     = i_element_count;
                    n_cnt   = '0;
                    n_idx   = '0;
                    n_ord   = '0;
                    n_m     = '0;
                    n_pend  = 1'b0;
                    n_acc   = '0;
                    if (!act_unrank) begin
                        n_state = S_RANK;
                    end else if (pts_eff == '0) begin
                        n_state = S_U_CHK;
                    end else begin
                        n_state = S_U_COUNT;
                    end
                end
            end

            // one position per cycle; a read issued here is summed next cycle
            S_RANK: begin
                if (r_pend) begin
                    n_acc = acc_sum;
                end
                tbl_req.row = C_CNT_W'(r_idx);
                tbl_req.col = r_ord + C_CNT_W'(1);
                n_pend = r_sub[0];
                if (r_sub[0]) begin
                    n_ord = r_ord + C_CNT_W'(1);
                end
                // restricted numbering skips blocked positions
                if (!(r_restr && r_blk[0])) begin
                    n_idx = r_idx + C_POS_W'(1);
                end
                n_sub = r_sub >> 1;
                n_blk = r_blk >> 1;
                n_cnt = r_cnt + C_POS_W'(1);
                if (r_cnt == C_POS_W'(C_MAX_POINTS - 1)) begin
                    n_state = S_RANK_LAST;
                end
            end

            S_RANK_LAST: begin
                n_answer = r_pend ? acc_sum : r_acc;
                n_flag   = 1'b0;
                n_strobe = 1'b1;
                n_state  = S_IDLE;
            end

            S_U_COUNT: begin
                if (cur_free) begin
                    n_m = r_m + C_CNT_W'(1);
                end
                n_cnt = r_cnt + C_POS_W'(1);
                if (r_cnt == pos_last) begin
                    n_state = S_U_CHK;
                end
            end

            S_U_CHK: begin
                tbl_req.row = r_m;
                tbl_req.col = r_k;
                if (r_k > r_m) begin
                    n_answer = '0;
                    n_flag   = 1'b1;
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_state = S_U_CHKW;
                end
            end

            // rank must be below C(m, k)
            S_U_CHKW: begin
                if (!diff[64]) begin
                    n_answer = '0;
                    n_flag   = 1'b1;
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end else if (r_k == '0) begin
                    n_answer = '0;
                    n_flag   = 1'b0;
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_idx   = C_POS_W'(r_m - C_CNT_W'(1));
                    n_ord   = r_k;
                    n_pos   = pos_last;
                    n_state = S_U_ALIGN;
                end
            end

            // walk down past blocked positions, then read C(idx, i)
            S_U_ALIGN: begin
                tbl_req.row = C_CNT_W'(r_idx);
                tbl_req.col = r_ord;
                if (pos_blocked) begin
                    n_pos = r_pos - C_POS_W'(1);
                end else begin
                    n_state = S_U_TEST;
                end
            end

            S_U_TEST: begin
                if ((r_idx != '0) && diff[64]) begin
                    // C(idx, i) > rank: try the next lower index
                    n_idx   = r_idx - C_POS_W'(1);
                    n_pos   = r_pos - C_POS_W'(1);
                    n_state = S_U_ALIGN;
                end else begin
                    n_rank = diff[63:0];
                    n_acc  = r_acc | (64'd1 << r_pos);
                    n_ord  = r_ord - C_CNT_W'(1);
                    if ((r_ord == C_CNT_W'(1)) || (r_idx == '0)) begin
                        n_answer = r_acc | (64'd1 << r_pos);
                        n_flag   = 1'b0;
                        n_strobe = 1'b1;
                        n_state  = S_IDLE;
                    end else begin
                        n_idx   = r_idx - C_POS_W'(1);
                        n_pos   = r_pos - C_POS_W'(1);
                        n_state = S_U_ALIGN;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_FILL;
            r_strobe <= 1'b0;
            r_pend   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            r_pend   <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt    <= n_cnt;
        r_idx    <= n_idx;
        r_pos    <= n_pos;
        r_ord    <= n_ord;
        r_m      <= n_m;
        r_k      <= n_k;
        r_restr  <= n_restr;
        r_acc    <= n_acc;
        r_rank   <= n_rank;
        r_sub    <= n_sub;
        r_blk    <= n_blk;
        r_answer <= n_answer;
        r_flag   <= n_flag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= 7'(C_MAX_POINTS);
        end else if (i_cfg_valid) begin
            r_point_count <= i_cfg_data;
        end
    end

    assign busy           = (r_state != S_IDLE);
    assign o_cfg_ready    = 1'b1;
    assign o_strobe       = r_strobe;
    assign o_answer       = r_answer;
    assign o_out_of_range = r_flag;

    // no result while the table is still being built
    a_no_result_in_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILL) |-> !o_strobe)
        else $error("result strobe during table fill");

    // a flagged result always carries an empty answer
    a_flag_zero_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_out_of_range) |-> (o_answer == '0))
        else $error("out_of_range with nonzero answer");

    // an accepted item holds off the next one
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepted item");

    // the strobe comes with the return to idle
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (r_state == S_IDLE))
        else $error("result strobe while still working");

    // the greedy walk never tests order zero
    a_order_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_U_TEST || r_state == S_U_ALIGN) |-> (r_ord != '0))
        else $error("unrank step with order zero");

endmodule

// ===== hw/rtl/scr_binom.sv =====
// Pascal triangle memory: builds C(r, c) after reset, then serves registered reads.
module scr_binom (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  scr_pkg::t_tbl_req i_req,
    output logic [63:0]       o_data,
    output logic              o_ready
);
    import scr_pkg::*;

    logic [63:0]         mem [C_TBL_DEPTH];
    logic [63:0]         r_rd;
    logic [63:0]         r_left;
    logic                r_filling;
    logic                r_phase;
    logic [C_CNT_W-1:0]  r_row;
    logic [C_CNT_W-1:0]  r_col;

    logic [C_CNT_W-1:0]  prev_row;
    logic [C_ADDR_W-1:0] raddr;
    logic [C_ADDR_W-1:0] waddr;
    logic [63:0]         prev_val;
    logic [63:0]         wval;

    assign prev_row = (r_row == '0) ? '0 : r_row - C_CNT_W'(1);
    assign raddr    = r_filling ? tbl_addr(prev_row, r_col) : tbl_addr(i_req.row, i_req.col);
    assign waddr    = tbl_addr(r_row, r_col);
    // row 0 has no row above: treat it as all zeros
    assign prev_val = (r_row == '0) ? 64'd0 : r_rd;
    assign wval     = (r_col == '0) ? 64'd1 : r_left + prev_val;

    always_ff @(posedge i_clk) begin
        if (r_filling && r_phase) begin
            mem[waddr] <= wval;
        end
        r_rd <= mem[raddr];
    end

    // left neighbor C(r-1, c-1) for the next column
    always_ff @(posedge i_clk) begin
        if (r_filling && r_phase) begin
            r_left <= prev_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filling <= 1'b1;
            r_phase   <= 1'b0;
            r_row     <= '0;
            r_col     <= '0;
        end else if (r_filling) begin
            r_phase <= ~r_phase;
            if (r_phase) begin
                if (r_col == C_CNT_W'(C_MAX_POINTS)) begin
                    r_col <= '0;
                    if (r_row == C_CNT_W'(C_MAX_POINTS)) begin
                        r_filling <= 1'b0;
                    end else begin
                        r_row <= r_row + C_CNT_W'(1);
                    end
                end else begin
                    r_col <= r_col + C_CNT_W'(1);
                end
            end
        end
    end

    assign o_data  = r_rd;
    assign o_ready = ~r_filling;

endmodule
